// File: src/spdpid_pkg.sv
// Shared types, constants and codes for the speed PID with manual override.
// Used by every module of the block; depends on nothing.
`default_nettype none

package spdpid_pkg;

  // Default fraction bits of speeds, error, integral and gains
  localparam int FRAC_BITS_DEF = 8;

  // Field and register widths
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int GAIN_W  = 16;
  localparam int LIMIT_W = 15;
  localparam int DRIVE_W = 7;
  localparam int ACCEL_W = 8;
  localparam int SP_W    = 8;
  localparam int MEAS_W  = 16;
  localparam int INTEG_W = 16;

  // tick_period is Q0.16
  localparam int TP_SHIFT = 16;

  // Output magnitude limit
  localparam logic [DRIVE_W-1:0] ACCEL_MAX = 7'd100;

  // Register reset values
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST      = 16'd6400;
  localparam logic [GAIN_W-1:0]  INT_GAIN_RST       = 16'd384;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST     = 16'd1024;
  localparam logic [GAIN_W-1:0]  TICK_PERIOD_RST    = 16'd5243;
  localparam logic [GAIN_W-1:0]  INVERSE_PERIOD_RST = 16'd3200;
  localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST = 15'd5120;
  localparam logic [DRIVE_W-1:0] MANUAL_DRIVE_RST   = 7'd70;

  // Register indexes (byte address is 4 * index)
  typedef enum logic [2:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INT_GAIN       = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_TICK_PERIOD    = 3'd3,
    REG_INVERSE_PERIOD = 3'd4,
    REG_INTEGRAL_LIMIT = 3'd5,
    REG_MANUAL_DRIVE   = 3'd6
  } reg_idx_t;

  // Configuration register file contents
  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  int_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [GAIN_W-1:0]  tick_period;
    logic [GAIN_W-1:0]  inverse_period;
    logic [LIMIT_W-1:0] integral_limit;
    logic [DRIVE_W-1:0] manual_drive;
  } cfg_t;

  // One input word
  typedef struct packed {
    logic                     auto_request;
    logic                     manual_request;
    logic                     stop_request;
    logic                     right_request;
    logic                     left_request;
    logic signed [SP_W-1:0]   speed_setpoint;
    logic signed [MEAS_W-1:0] measured_speed;
    logic                     inspecting;
  } in_word_t;

  // Datapath operations, one per cycle on the shared multiplier
  typedef enum logic [2:0] {
    OP_NONE,
    OP_MUL_I,
    OP_MUL_D,
    OP_MUL_P,
    OP_MUL_K,
    OP_MUL_G,
    OP_SUM
  } op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_I,
    ST_MUL_D,
    ST_MUL_P,
    ST_MUL_K,
    ST_MUL_G,
    ST_SUM,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    op_t  op;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic auto_mode;
  } stat_t;

endpackage

`default_nettype wire

// File: src/spdpid_cfg.sv
// APB-style configuration register file for the speed PID.
// Depends on spdpid_pkg for register indexes, widths and reset values.
`default_nettype none

module spdpid_cfg import spdpid_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg    = cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain      <= PROP_GAIN_RST;
      cfg_r.int_gain       <= INT_GAIN_RST;
      cfg_r.deriv_gain     <= DERIV_GAIN_RST;
      cfg_r.tick_period    <= TICK_PERIOD_RST;
      cfg_r.inverse_period <= INVERSE_PERIOD_RST;
      cfg_r.integral_limit <= INTEGRAL_LIMIT_RST;
      cfg_r.manual_drive   <= MANUAL_DRIVE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_PROP_GAIN:      cfg_r.prop_gain      <= pwdata[GAIN_W-1:0];
        REG_INT_GAIN:       cfg_r.int_gain       <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN:     cfg_r.deriv_gain     <= pwdata[GAIN_W-1:0];
        REG_TICK_PERIOD:    cfg_r.tick_period    <= pwdata[GAIN_W-1:0];
        REG_INVERSE_PERIOD: cfg_r.inverse_period <= pwdata[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: cfg_r.integral_limit <= pwdata[LIMIT_W-1:0];
        REG_MANUAL_DRIVE:   cfg_r.manual_drive   <= pwdata[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_PROP_GAIN:      prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_r.prop_gain};
      REG_INT_GAIN:       prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_r.int_gain};
      REG_DERIV_GAIN:     prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_r.deriv_gain};
      REG_TICK_PERIOD:    prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_r.tick_period};
      REG_INVERSE_PERIOD: prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_r.inverse_period};
      REG_INTEGRAL_LIMIT: prdata = {{(DATA_W-LIMIT_W){1'b0}}, cfg_r.integral_limit};
      REG_MANUAL_DRIVE:   prdata = {{(DATA_W-DRIVE_W){1'b0}}, cfg_r.manual_drive};
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: src/spdpid_ctrl.sv
// Sequencer for the speed PID: steps the shared multiplier and owns the handshakes.
// Depends on spdpid_pkg for state, operation and command types.
`default_nettype none

module spdpid_ctrl import spdpid_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.auto_mode ? ST_MUL_I : ST_OUT;
        end
      end
      ST_MUL_I: begin
        cmd.op    = OP_MUL_I;
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.op    = OP_MUL_D;
        state_nxt = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd.op    = OP_MUL_P;
        state_nxt = ST_MUL_K;
      end
      ST_MUL_K: begin
        cmd.op    = OP_MUL_K;
        state_nxt = ST_MUL_G;
      end
      ST_MUL_G: begin
        cmd.op    = OP_MUL_G;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // wait here while the previous word still sits in the output register
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register occupancy
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

`default_nettype wire

// File: src/spdpid_dp.sv
// Datapath of the speed PID: error, one shared multiplier, integral, accumulator,
// manual override and the output register. Depends on spdpid_pkg.
`default_nettype none

module spdpid_dp import spdpid_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire in_word_t                  in_word,
  input  wire cfg_t                      cfg,
  input  wire cmd_t                      cmd,
  output stat_t                          stat,
  output logic signed [ACCEL_W-1:0]      acceleration,
  output logic                           camera_on,
  output logic                           setpoint_clear
);

  // Widths derived from the fraction bits
  localparam int EW    = (FRAC_BITS + 9 > 17) ? FRAC_BITS + 9 : 17;  // error
  localparam int DFW   = EW + 1;                                    // error difference
  localparam int BW    = GAIN_W + 1;                                // unsigned gain as signed
  localparam int MA    = DFW + BW - FRAC_BITS;                      // multiplier A / derivative
  localparam int PW    = MA + BW;                                   // product
  localparam int INCW  = PW - TP_SHIFT;                             // integral increment
  localparam int ISW   = INCW + 1;                                  // integral sum
  localparam int ACW   = PW + 2;                                    // PID sum
  localparam int SHIFT2 = 2 * FRAC_BITS;

  localparam logic signed [ACW-1:0] SUM_MAX =
    {{(ACW-DRIVE_W){1'b0}}, ACCEL_MAX} << SHIFT2;
  localparam logic signed [ACW-1:0] SUM_MIN = -SUM_MAX;
  localparam logic signed [ACW-1:0] RND_ADD = (ACW'(1) << SHIFT2) - ACW'(1);

  // State and working registers
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [EW-1:0]      prev_r;
  logic                      prev_auto_r;
  logic signed [EW-1:0]      err_r;
  logic signed [PW-1:0]      p_r;
  logic signed [MA-1:0]      d_r;
  logic signed [ACW-1:0]     acc_r;
  logic                      auto_r;
  logic                      cam_r;
  logic                      clr_r;
  logic signed [ACCEL_W-1:0] man_r;
  logic signed [ACCEL_W-1:0] accel_out_r;
  logic                      cam_out_r;
  logic                      clr_out_r;

  logic                      auto_m;
  logic signed [SP_W-1:0]    sp_cap;
  logic signed [EW-1:0]      sp_ext;
  logic signed [EW-1:0]      meas_ext;
  logic signed [EW-1:0]      err_nxt;
  logic signed [DFW-1:0]     diff;
  logic signed [MA-1:0]      mul_a;
  logic signed [BW-1:0]      mul_b;
  logic signed [PW-1:0]      mul_p;
  logic signed [INCW-1:0]    inc;
  logic signed [ISW-1:0]     isum;
  logic signed [ISW-1:0]     lim_pos;
  logic signed [ISW-1:0]     lim_neg;
  logic signed [ISW-1:0]     iclamp;
  logic signed [INTEG_W-1:0] integ_nxt;
  logic signed [MA-1:0]      d_nxt;
  logic signed [ACW-1:0]     p_ext;
  logic signed [ACW-1:0]     sum_c;
  logic signed [ACW-1:0]     sum_t;
  logic signed [ACW-1:0]     sum_q;
  logic [DRIVE_W-1:0]        drive;
  logic signed [ACCEL_W-1:0] man_nxt;

  assign acceleration   = accel_out_r;
  assign camera_on      = cam_out_r;
  assign setpoint_clear = clr_out_r;

  // Mode and error of the incoming word
  assign auto_m         = in_word.auto_request & ~in_word.manual_request;
  assign stat.auto_mode = auto_m;

  always_comb begin
    sp_cap = in_word.speed_setpoint;
    // inspection caps a positive setpoint at zero
    if (in_word.inspecting && !in_word.speed_setpoint[SP_W-1] &&
        (in_word.speed_setpoint != '0)) begin
      sp_cap = '0;
    end
  end

  assign sp_ext   = {{(EW-SP_W-FRAC_BITS){sp_cap[SP_W-1]}}, sp_cap, {FRAC_BITS{1'b0}}};
  assign meas_ext = {{(EW-MEAS_W){in_word.measured_speed[MEAS_W-1]}}, in_word.measured_speed};
  assign err_nxt  = sp_ext - meas_ext;
  assign diff     = {err_r[EW-1], err_r} - {prev_r[EW-1], prev_r};

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_I: begin
        mul_a = {{(MA-EW){err_r[EW-1]}}, err_r};
        mul_b = {1'b0, cfg.tick_period};
      end
      OP_MUL_D: begin
        mul_a = {{(MA-DFW){diff[DFW-1]}}, diff};
        mul_b = {1'b0, cfg.inverse_period};
      end
      OP_MUL_P: begin
        mul_a = {{(MA-EW){err_r[EW-1]}}, err_r};
        mul_b = {1'b0, cfg.prop_gain};
      end
      OP_MUL_K: begin
        mul_a = {{(MA-INTEG_W){integ_r[INTEG_W-1]}}, integ_r};
        mul_b = {1'b0, cfg.int_gain};
      end
      OP_MUL_G: begin
        mul_a = d_r;
        mul_b = {1'b0, cfg.deriv_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Integral update: floor shift of error * period, then symmetric clamp
  assign inc     = $signed(p_r[PW-1:TP_SHIFT]);
  assign isum    = $signed({inc[INCW-1], inc}) +
                   $signed({{(ISW-INTEG_W){integ_r[INTEG_W-1]}}, integ_r});
  assign lim_pos = $signed({{(ISW-LIMIT_W){1'b0}}, cfg.integral_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (isum > lim_pos) begin
      iclamp = lim_pos;
    end else if (isum < lim_neg) begin
      iclamp = lim_neg;
    end else begin
      iclamp = isum;
    end
  end

  assign integ_nxt = iclamp[INTEG_W-1:0];

  // Derivative: floor shift of difference * inverse period
  assign d_nxt = $signed(p_r[FRAC_BITS +: MA]);
  assign p_ext = {{(ACW-PW){p_r[PW-1]}}, p_r};

  // Output saturation, then truncation toward zero
  always_comb begin
    if (acc_r > SUM_MAX) begin
      sum_c = SUM_MAX;
    end else if (acc_r < SUM_MIN) begin
      sum_c = SUM_MIN;
    end else begin
      sum_c = acc_r;
    end
  end

  assign sum_t = sum_c[ACW-1] ? sum_c + RND_ADD : sum_c;
  assign sum_q = sum_t >>> SHIFT2;

  // Manual override: stop, then right, then left
  assign drive = (cfg.manual_drive > ACCEL_MAX) ? ACCEL_MAX : cfg.manual_drive;

  always_comb begin
    if (in_word.stop_request) begin
      man_nxt = '0;
    end else if (in_word.right_request) begin
      man_nxt = $signed({1'b0, drive});
    end else if (in_word.left_request) begin
      man_nxt = $signed(ACCEL_W'(0) - {1'b0, drive});
    end else begin
      man_nxt = '0;
    end
  end

  // Controller state: integral, previous error, previous mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      prev_r      <= '0;
      prev_auto_r <= 1'b1;
    end else begin
      if (cmd.load) begin
        prev_auto_r <= auto_m;
        // manual mode or a mode change clears the history
        if (!auto_m || (auto_m != prev_auto_r)) begin
          integ_r <= '0;
          prev_r  <= '0;
        end
      end
      if (cmd.op == OP_MUL_D) begin
        integ_r <= integ_nxt;
        prev_r  <= err_r;
      end
    end
  end

  // Working and output registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_r  <= err_nxt;
      auto_r <= auto_m;
      cam_r  <= in_word.inspecting;
      clr_r  <= ~auto_m & in_word.stop_request;
      man_r  <= man_nxt;
    end
    if (cmd.op != OP_NONE) begin
      p_r <= mul_p;
    end
    case (cmd.op)
      OP_MUL_P: d_r   <= d_nxt;
      OP_MUL_K: acc_r <= p_ext;
      OP_MUL_G: acc_r <= acc_r + p_ext;
      OP_SUM:   acc_r <= acc_r + p_ext;
      default: ;
    endcase
    if (cmd.out_load) begin
      accel_out_r <= auto_r ? sum_q[ACCEL_W-1:0] : man_r;
      cam_out_r   <= cam_r;
      clr_out_r   <= clr_r;
    end
  end

endmodule

`default_nettype wire

// File: src/speed_pid_with_manual_override.sv
// Speed PID controller with manual override.
// In: one word per control tick (command flags, setpoint, measured speed,
// inspection flag) on a valid/ready channel. Out: one word per input word
// (acceleration in -100..100, camera_on, setpoint_clear) on a valid/ready
// channel. Gains, period, integral limit and manual drive sit in an APB-style
// register file at byte address 4 * index; pready is always high.
// An automatic-mode word steps through MUL_I, MUL_D, MUL_P, MUL_K, MUL_G, SUM
// and OUT after it is accepted, a manual-mode word goes straight to OUT, and
// out_valid is registered on leaving OUT. One word is in work at a time, so
// no new word is taken until the sequencer is idle again; the five products
// share one multiplier, one per cycle; the sequencer steps through them in turn.
// in_ready is high whenever the sequencer is idle, also while a result waits
// in the output register; if the receiver stalls, the next result holds in
// the sequencer until the output register frees up.
// Reset (rst_n low, synchronous) loads the register defaults, clears the
// integral and previous error, selects automatic as the previous mode and
// empties the output register.
`default_nettype none

module speed_pid_with_manual_override import spdpid_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // configuration port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [ADDR_W-1:0]        paddr,
  input  wire logic [DATA_W-1:0]        pwdata,
  output logic      [DATA_W-1:0]        prdata,
  output logic                          pready,
  // input channel
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_auto_request,
  input  wire logic                     in_manual_request,
  input  wire logic                     in_stop_request,
  input  wire logic                     in_right_request,
  input  wire logic                     in_left_request,
  input  wire logic signed [SP_W-1:0]   in_speed_setpoint,
  input  wire logic signed [MEAS_W-1:0] in_measured_speed,
  input  wire logic                     in_inspecting,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [ACCEL_W-1:0]     out_acceleration,
  output logic                          out_camera_on,
  output logic                          out_setpoint_clear
);

  cfg_t     cfg;
  cmd_t     cmd;
  stat_t    stat;
  in_word_t in_word;

  // Input word
  assign in_word.auto_request   = in_auto_request;
  assign in_word.manual_request = in_manual_request;
  assign in_word.stop_request   = in_stop_request;
  assign in_word.right_request  = in_right_request;
  assign in_word.left_request   = in_left_request;
  assign in_word.speed_setpoint = in_speed_setpoint;
  assign in_word.measured_speed = in_measured_speed;
  assign in_word.inspecting     = in_inspecting;

  spdpid_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spdpid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spdpid_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_word        (in_word),
    .cfg            (cfg),
    .cmd            (cmd),
    .stat           (stat),
    .acceleration   (out_acceleration),
    .camera_on      (out_camera_on),
    .setpoint_clear (out_setpoint_clear)
  );

`ifndef SYNTH
  // one word in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a word is in work");

  // result always within the drive limit
  a_accel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_acceleration <= 8'sd100) && (out_acceleration >= -8'sd100)))
    else $error("acceleration out of range");

  // a stop result never drives
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_setpoint_clear) |-> (out_acceleration == '0))
    else $error("setpoint clear with nonzero acceleration");
`endif

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for speed_pid_with_manual_override: random and directed
// control ticks, APB register writes, and a scoreboard class that predicts each word.
// Depends on spdpid_pkg and the block's RTL only.

module testbench;
  import spdpid_pkg::*;

  localparam int  CYCLE_LIMIT = 400000;
  localparam int  DRAIN_WAIT  = 12;   // extra wait after the last expected word
  localparam int  ONE_F       = 1 << FRAC_BITS_DEF;
  localparam longint ONE_2F   = longint'(1) << (2 * FRAC_BITS_DEF);

  // One result word
  typedef struct {
    logic signed [ACCEL_W-1:0] accel;
    logic                      camera;
    logic                      sp_clear;
  } accel_word_t;

  // Predicts the acceleration word for every accepted tick and checks results
  class accel_scoreboard;
    longint      kp, ki, kd, tp, ip, lim, drive;
    longint      integral, prev_error;
    bit          prev_auto;
    accel_word_t expected_words[$];
    int          n_err;

    function new();
      kp = PROP_GAIN_RST;
      ki = INT_GAIN_RST;
      kd = DERIV_GAIN_RST;
      tp = TICK_PERIOD_RST;
      ip = INVERSE_PERIOD_RST;
      lim = INTEGRAL_LIMIT_RST;
      drive = MANUAL_DRIVE_RST;
      integral = 0;
      prev_error = 0;
      prev_auto = 1'b1;
      n_err = 0;
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      n_err++;
    endtask

    function void note_register(reg_idx_t idx, logic [DATA_W-1:0] v);
      case (idx)
        REG_PROP_GAIN:      kp = v[GAIN_W-1:0];
        REG_INT_GAIN:       ki = v[GAIN_W-1:0];
        REG_DERIV_GAIN:     kd = v[GAIN_W-1:0];
        REG_TICK_PERIOD:    tp = v[GAIN_W-1:0];
        REG_INVERSE_PERIOD: ip = v[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: lim = v[LIMIT_W-1:0];
        REG_MANUAL_DRIVE:   drive = v[DRIVE_W-1:0];
        default: ;
      endcase
    endfunction

    // Work out the word the block owes for one accepted tick
    function void note_tick(in_word_t w);
      bit          auto_mode;
      longint      sp, meas, err, deriv, total, accel, drv;
      accel_word_t r;
      auto_mode = w.auto_request && !w.manual_request;
      if (auto_mode != prev_auto) begin
        integral = 0;
        prev_error = 0;
        prev_auto = auto_mode;
      end
      r.camera = w.inspecting;
      r.sp_clear = 1'b0;
      if (auto_mode) begin
        sp = w.speed_setpoint;
        meas = w.measured_speed;
        if (w.inspecting && sp > 0) sp = 0;
        err = sp * ONE_F - meas;
        integral = integral + ((err * tp) >>> TP_SHIFT);
        if (integral > lim) integral = lim;
        if (integral < -lim) integral = -lim;
        deriv = ((err - prev_error) * ip) >>> FRAC_BITS_DEF;
        prev_error = err;
        total = kp * err + ki * integral + kd * deriv;
        if (total > 100 * ONE_2F) total = 100 * ONE_2F;
        if (total < -100 * ONE_2F) total = -100 * ONE_2F;
        accel = total / ONE_2F;  // truncates toward zero
      end else begin
        integral = 0;
        prev_error = 0;
        drv = (drive > 100) ? 100 : drive;
        if (w.stop_request) begin
          accel = 0;
          r.sp_clear = 1'b1;
        end else if (w.right_request) begin
          accel = drv;
        end else if (w.left_request) begin
          accel = -drv;
        end else begin
          accel = 0;
        end
      end
      r.accel = accel[ACCEL_W-1:0];
      expected_words.push_back(r);
    endfunction

    task check_word(accel_word_t got);
      accel_word_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word accel=%0d", got.accel));
      end else begin
        want = expected_words.pop_front();
        if (got.accel !== want.accel)
          report($sformatf("acceleration got %0d want %0d", got.accel, want.accel));
        if (got.camera !== want.camera)
          report($sformatf("camera_on got %b want %b", got.camera, want.camera));
        if (got.sp_clear !== want.sp_clear)
          report($sformatf("setpoint_clear got %b want %b", got.sp_clear, want.sp_clear));
      end
    endtask

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     psel, penable, pwrite;
  logic [ADDR_W-1:0]        paddr;
  logic [DATA_W-1:0]        pwdata;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;
  logic                     in_valid, in_ready;
  logic                     in_auto_request, in_manual_request, in_stop_request;
  logic                     in_right_request, in_left_request, in_inspecting;
  logic signed [SP_W-1:0]   in_speed_setpoint;
  logic signed [MEAS_W-1:0] in_measured_speed;
  logic                     out_valid, out_ready;
  logic signed [ACCEL_W-1:0] out_acceleration;
  logic                     out_camera_on, out_setpoint_clear;

  accel_scoreboard sb = new();
  bit              no_idle = 1'b0;
  int              rx_hold_req = 0;
  int              cycles = 0;

  speed_pid_with_manual_override i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_auto_request    (in_auto_request),
    .in_manual_request  (in_manual_request),
    .in_stop_request    (in_stop_request),
    .in_right_request   (in_right_request),
    .in_left_request    (in_left_request),
    .in_speed_setpoint  (in_speed_setpoint),
    .in_measured_speed  (in_measured_speed),
    .in_inspecting      (in_inspecting),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_acceleration   (out_acceleration),
    .out_camera_on      (out_camera_on),
    .out_setpoint_clear (out_setpoint_clear)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 10);
  endfunction

  function automatic in_word_t mk_word(bit au, bit man, bit stp, bit rgt, bit lft,
                                       int sp, int meas, bit insp);
    in_word_t w;
    w.auto_request = au;
    w.manual_request = man;
    w.stop_request = stp;
    w.right_request = rgt;
    w.left_request = lft;
    w.speed_setpoint = sp[SP_W-1:0];
    w.measured_speed = meas[MEAS_W-1:0];
    w.inspecting = insp;
    return w;
  endfunction

  // APB write: setup cycle, then access cycle; called at a falling edge
  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] v);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_W'(idx) << 2;
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.note_register(idx, v);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_all_regs(int kp, int ki, int kd, int tp, int ip, int lim, int drv);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INT_GAIN, ki);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_TICK_PERIOD, tp);
    write_reg(REG_INVERSE_PERIOD, ip);
    write_reg(REG_INTEGRAL_LIMIT, lim);
    write_reg(REG_MANUAL_DRIVE, drv);
  endtask

  // Offer one word; called and returns at a falling edge
  task automatic put_word(in_word_t w);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_auto_request = w.auto_request;
    in_manual_request = w.manual_request;
    in_stop_request = w.stop_request;
    in_right_request = w.right_request;
    in_left_request = w.left_request;
    in_speed_setpoint = w.speed_setpoint;
    in_measured_speed = w.measured_speed;
    in_inspecting = w.inspecting;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(w);
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected word has come back
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Random ticks: mostly automatic runs that track the setpoint, some manual bursts
  task automatic run_random(int n);
    int     sent, len, sp;
    longint m;
    bit     au, man, insp;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(1, 12);
        if (len > n - sent) len = n - sent;
        sp = $signed(8'($urandom()));
        insp = ($urandom_range(0, 3) == 0);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0, 1: m = sp * ONE_F + int'($urandom_range(0, 1200)) - 600;
            2: m = sp * ONE_F + int'($urandom_range(0, 40)) - 20;
            default: m = $signed(16'($urandom()));
          endcase
          if (m > 32767) m = 32767;
          if (m < -32768) m = -32768;
          if ($urandom_range(0, 7) == 0) insp = ~insp;
          put_word(mk_word(1'b1, 1'b0, $urandom_range(0, 1), $urandom_range(0, 1),
                           $urandom_range(0, 1), sp, int'(m), insp));
          sent++;
        end
      end else begin
        len = $urandom_range(1, 6);
        if (len > n - sent) len = n - sent;
        repeat (len) begin
          au = $urandom_range(0, 1);
          man = au ? 1'b1 : 1'(($urandom_range(0, 1)));
          put_word(mk_word(au, man, ($urandom_range(0, 3) == 0), $urandom_range(0, 1),
                           $urandom_range(0, 1), $signed(8'($urandom())),
                           $signed(16'($urandom())), $urandom_range(0, 1)));
          sent++;
        end
      end
    end
  endtask

  // Result side: random stalls, or a long hold-off when asked
  initial begin
    accel_word_t got;
    int          stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        stall = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      got.accel = out_acceleration;
      got.camera = out_camera_on;
      got.sp_clear = out_setpoint_clear;
      sb.check_word(got);
      @(negedge clk);
    end
  end

  // Main sequence
  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_auto_request = 1'b0;
    in_manual_request = 1'b0;
    in_stop_request = 1'b0;
    in_right_request = 1'b0;
    in_left_request = 1'b0;
    in_speed_setpoint = '0;
    in_measured_speed = '0;
    in_inspecting = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed ticks at reset defaults
    put_word(mk_word(1, 0, 0, 0, 0, 0, 0, 0));
    put_word(mk_word(1, 0, 0, 0, 0, 127, -32768, 0));       // largest error
    put_word(mk_word(1, 0, 0, 0, 0, -128, 32767, 0));       // smallest error
    put_word(mk_word(1, 0, 0, 0, 0, 10, 10 * 256 - 50, 0));
    put_word(mk_word(1, 0, 0, 0, 0, 10, 10 * 256 - 50, 0));
    put_word(mk_word(1, 0, 1, 1, 1, 50, 0, 1));             // setpoint capped while inspecting
    put_word(mk_word(1, 0, 0, 0, 0, -20, 0, 1));            // negative setpoint not capped
    put_word(mk_word(0, 1, 1, 1, 1, 5, 100, 0));            // stop wins
    put_word(mk_word(0, 1, 0, 1, 1, 5, 100, 1));            // right wins over left
    put_word(mk_word(0, 1, 0, 0, 1, 5, 100, 0));
    put_word(mk_word(0, 1, 0, 0, 0, 5, 100, 0));
    put_word(mk_word(1, 0, 0, 0, 0, 3, 0, 0));              // back to automatic
    put_word(mk_word(1, 1, 0, 0, 1, 3, 0, 0));              // manual overrides auto
    put_word(mk_word(0, 0, 0, 1, 0, 3, 0, 0));              // neither requested
    put_word(mk_word(1, 0, 0, 0, 0, 1, 1, 0));
    put_word(mk_word(1, 0, 0, 0, 0, -1, -1, 1));
    drain();

    // Every register at its maximum; drive above 100 saturates
    set_all_regs(65535, 65535, 65535, 65535, 65535, 32767, 127);
    put_word(mk_word(0, 1, 0, 1, 0, 0, 0, 0));
    put_word(mk_word(0, 1, 0, 0, 1, 0, 0, 0));
    put_word(mk_word(1, 0, 0, 0, 0, 1, 200, 0));
    put_word(mk_word(1, 0, 0, 0, 0, 1, 200, 0));
    run_random(70);
    drain();

    // Every register at zero, periods included
    set_all_regs(0, 0, 0, 0, 0, 0, 0);
    put_word(mk_word(0, 1, 0, 1, 0, 0, 0, 0));
    put_word(mk_word(1, 0, 0, 0, 0, 127, -32768, 0));
    run_random(50);
    drain();

    // Random settings, small limit and modest gains mixed in
    repeat (3) begin
      set_all_regs($urandom_range(0, 65535), $urandom_range(0, 4095),
                   $urandom_range(0, 65535), $urandom_range(1, 65535),
                   $urandom_range(1, 65535), $urandom_range(0, 32767),
                   $urandom_range(0, 127));
      run_random(60);
      drain();
    end
    set_all_regs(256, 128, 16, 65535, 256, 300, $urandom_range(101, 127));
    run_random(50);
    drain();

    // Back to defaults; long result hold-off while words keep coming
    set_all_regs(PROP_GAIN_RST, INT_GAIN_RST, DERIV_GAIN_RST, TICK_PERIOD_RST,
                 INVERSE_PERIOD_RST, INTEGRAL_LIMIT_RST, MANUAL_DRIVE_RST);
    rx_hold_req = 300;
    no_idle = 1'b1;
    run_random(40);
    no_idle = 1'b0;
    run_random(40);
    drain();

    if (sb.n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
src/spdpid_pkg.sv
src/spdpid_cfg.sv
src/spdpid_ctrl.sv
src/spdpid_dp.sv
src/speed_pid_with_manual_override.sv
sim/testbench.sv
